[hdl/spf_pkg.sv]
// ----------------------------------------------------------------------------
// spf_pkg
// Shared types and constants of the S/PDIF / analog PCM frame formatter.
// ----------------------------------------------------------------------------
package spf_pkg;

    // channel status block length in frames
    localparam int STATUS_FRAMES = 192;
    localparam int POS_W         = 8;
    localparam int STATUS_W      = 64;
    localparam int CFG_INDEX_W   = 3;

    // preamble codes in bits 1..0 of a subframe word
    localparam logic [1:0] PREAMBLE_B = 2'd0;
    localparam logic [1:0] PREAMBLE_W = 2'd1;
    localparam logic [1:0] PREAMBLE_M = 2'd2;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_MODE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STEREO        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BYTE_ORDER    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_STATUS_FIRST  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_STATUS_MIDDLE = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_STATUS_LAST   = 3'd5;

    // one formatted frame waiting for the output side
    typedef struct packed {
        logic [31:0] word0;
        logic [31:0] word1;
        logic        two;
    } job_t;

endpackage

[hdl/spf_front.sv]
// ----------------------------------------------------------------------------
// spf_front
// Configuration registers, frame position and formatting of one frame into
// one or two output words.
// ----------------------------------------------------------------------------
module spf_front
    import spf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [STATUS_W-1:0]    cfg_data,
    input  logic                   accept,
    input  logic [7:0]             byte0,
    input  logic [7:0]             byte1,
    input  logic [7:0]             byte2,
    input  logic [7:0]             byte3,
    input  logic                   mute,
    output job_t                   job
);

    logic                output_mode_reg;
    logic                stereo_reg;
    logic                byte_order_reg;
    logic [STATUS_W-1:0] status_first_reg;
    logic [STATUS_W-1:0] status_middle_reg;
    logic [STATUS_W-1:0] status_last_reg;
    logic [POS_W-1:0]    frame_position_reg;
    logic [POS_W-1:0]    frame_position_next;

    logic [3*STATUS_W-1:0] status_vec;
    logic [POS_W-1:0]      status_idx;
    logic                  status_bit;
    logic [15:0]           left;
    logic [15:0]           right;
    logic [1:0]            pre;
    logic [31:0]           analog_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            output_mode_reg    <= 1'b0;
            stereo_reg         <= 1'b1;
            byte_order_reg     <= 1'b0;
            status_first_reg   <= '0;
            status_middle_reg  <= '0;
            status_last_reg    <= '0;
            frame_position_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_OUTPUT_MODE:   output_mode_reg   <= cfg_data[0];
                    REG_STEREO:        stereo_reg        <= cfg_data[0];
                    REG_BYTE_ORDER:    byte_order_reg    <= cfg_data[0];
                    REG_STATUS_FIRST:  status_first_reg  <= cfg_data;
                    REG_STATUS_MIDDLE: status_middle_reg <= cfg_data;
                    REG_STATUS_LAST:   status_last_reg   <= cfg_data;
                    default:           ;
                endcase
            end
            frame_position_reg <= frame_position_next;
        end
    end

    always_comb
    begin
        frame_position_next = frame_position_reg;
        if (accept && output_mode_reg)
        begin
            if (frame_position_reg == POS_W'(STATUS_FRAMES - 1))
                frame_position_next = '0;
            else
                frame_position_next = frame_position_reg + 1'b1;
        end
    end

    // bit 0 of the status block sits at the top of the concatenation
    assign status_vec = {status_first_reg, status_middle_reg, status_last_reg};
    assign status_idx = POS_W'(STATUS_FRAMES - 1) - frame_position_reg;
    assign status_bit = status_vec[status_idx];
    assign pre        = (frame_position_reg == '0) ? PREAMBLE_B : PREAMBLE_M;

    always_comb
    begin
        if (byte_order_reg)
        begin
            left  = {byte0, byte1};
            right = stereo_reg ? {byte2, byte3} : {byte0, byte1};
        end
        else
        begin
            left  = {byte1, byte0};
            right = stereo_reg ? {byte3, byte2} : {byte1, byte0};
        end
        if (mute)
        begin
            left  = '0;
            right = '0;
        end
    end

    always_comb
    begin
        case ({byte_order_reg, stereo_reg})
            2'b01:   analog_word = {byte3, byte2, byte1, byte0};
            2'b00:   analog_word = {byte1, byte0, byte1, byte0};
            2'b11:   analog_word = {byte2, byte3, byte0, byte1};
            default: analog_word = {byte0, byte1, byte0, byte1};
        endcase
    end

    always_comb
    begin
        if (output_mode_reg)
        begin
            job.word0 = {1'b0, status_bit, 2'b00, left, 10'b0, pre};
            job.word1 = {1'b0, status_bit, 2'b00, right, 10'b0, PREAMBLE_W};
            job.two   = 1'b1;
        end
        else
        begin
            job.word0 = analog_word;
            job.word1 = analog_word;
            job.two   = 1'b0;
        end
    end

endmodule

[hdl/spf_queue.sv]
// ----------------------------------------------------------------------------
// spf_queue
// Small first-in first-out store of formatted frames between front and back.
// ----------------------------------------------------------------------------
module spf_queue
    import spf_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic empty,
    output logic full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

[hdl/spf_back.sv]
// ----------------------------------------------------------------------------
// spf_back
// Output side: takes formatted frames off the queue and sends their words
// through an output register, one word per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module spf_back
    import spf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  job_t        head,
    input  logic        empty,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] word,
    output logic        last
);

    logic        valid_reg;
    logic        valid_next;
    logic        second_reg;
    logic        second_next;
    logic [31:0] word_reg;
    logic [31:0] word_next;
    logic        last_reg;
    logic        last_next;
    logic        load;

    assign load = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next  = valid_reg;
        second_next = second_reg;
        word_next   = word_reg;
        last_next   = last_reg;
        pop         = 1'b0;
        if (load)
        begin
            // head stays queued until its last word is loaded
            if (second_reg)
            begin
                valid_next  = 1'b1;
                word_next   = head.word1;
                last_next   = 1'b1;
                second_next = 1'b0;
                pop         = 1'b1;
            end
            else if (!empty)
            begin
                valid_next  = 1'b1;
                word_next   = head.word0;
                last_next   = !head.two;
                second_next = head.two;
                pop         = !head.two;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign word      = word_reg;
    assign last      = last_reg;

endmodule

[hdl/spdif_pcm_frame_formatter_core.sv]
// ----------------------------------------------------------------------------
// spdif_pcm_frame_formatter_core
// Formats 16-bit PCM frames into analog words or S/PDIF subframe words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): one frame per item, byte0..byte3 in
//   memory order plus mute. Output channel (out_valid/out_stall): word and
//   last, one or two word items per accepted frame. Config channel
//   (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the registers;
//   cfg_ready is always high. The user must make writes only while the
//   block is idle; the block itself does not enforce this. Analog mode
//   gives one word per frame, S/PDIF mode two (left, right), with last
//   marking the final word of the frame. An accepted frame is written
//   into the queue and then loaded into the output register, which sends
//   one word per cycle while out_stall is low and so sets the frame rate.
//   The front formats a frame in the accept cycle and writes it into a
//   QUEUE_DEPTH-entry queue; in_stall is high while that queue is full.
//   When the receiver stalls, the output word holds and the queue fills.
//   Reset empties the queue and output, sets the frame position to 0 and
//   loads register defaults (analog, stereo, little-endian, status zero).
// ----------------------------------------------------------------------------
module spdif_pcm_frame_formatter_core
    import spf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [STATUS_W-1:0]    cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             byte0,
    input  logic [7:0]             byte1,
    input  logic [7:0]             byte2,
    input  logic [7:0]             byte3,
    input  logic                   mute,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [31:0]            word,
    output logic                   last
);

    job_t front_job;
    job_t head;
    logic accept;
    logic pop;
    logic empty;
    logic full;

    assign cfg_ready = 1'b1;
    assign in_stall  = full;
    assign accept    = in_valid && !full;

    spf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .byte0     (byte0),
        .byte1     (byte1),
        .byte2     (byte2),
        .byte3     (byte3),
        .mute      (mute),
        .job       (front_job)
    );

    spf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept),
        .push_job (front_job),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    spf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .word      (word),
        .last      (last)
    );

endmodule

[hdl/spf_checker.sv]
// ----------------------------------------------------------------------------
// spf_checker
// Port-level checks of the frame formatter, bound to the top level.
// ----------------------------------------------------------------------------
module spf_checker
    import spf_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] word,
    input logic        last
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(word) && $stable(last))
        else $error("output word changed while stalled");

    // a left subframe is followed at once by its right subframe
    a_right_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid && last && word[1:0] == PREAMBLE_W)
        else $error("right subframe did not follow left subframe");

    // a left subframe carries preamble B or M and zero padding bits
    a_left_format: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> (word[1:0] == PREAMBLE_B || word[1:0] == PREAMBLE_M)
            && word[31] == 1'b0 && word[29:28] == 2'b00 && word[11:2] == 10'd0)
        else $error("malformed left subframe");

endmodule

bind spdif_pcm_frame_formatter_core spf_checker u_spf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .word      (word),
    .last      (last)
);

[tb/sv/spf_frame_board_pkg.sv]
// ----------------------------------------------------------------------------
// spf_frame_board_pkg
// Expected-word tracking for the PCM frame formatter testbench: keeps its own
// copy of the format registers, the channel status block and the frame
// position, and turns each accepted frame into the words it should produce.
// ----------------------------------------------------------------------------
package spf_frame_board_pkg;

    import spf_pkg::*;

    // indexes past the register map, writes there must be dropped
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 3'd7;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } out_word_t;

    class frame_board;
        logic                  spdif_mode;
        logic                  stereo;
        logic                  big_endian;
        // channel status bit 0 sits at the top
        logic [3*STATUS_W-1:0] status_block;
        logic [POS_W-1:0]      frame_pos;
        out_word_t             pending_words[$];
        int                    errors;
        int                    words_checked;
        int                    analog_frames;
        int                    spdif_frames;
        int                    muted_frames;
        int                    block_wraps;

        function new();
            spdif_mode    = 1'b0;
            stereo        = 1'b1;
            big_endian    = 1'b0;
            status_block  = '0;
            frame_pos     = '0;
            errors        = 0;
            words_checked = 0;
            analog_frames = 0;
            spdif_frames  = 0;
            muted_frames  = 0;
            block_wraps   = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [STATUS_W-1:0] data);
            case (idx)
                REG_OUTPUT_MODE:   spdif_mode = data[0];
                REG_STEREO:        stereo = data[0];
                REG_BYTE_ORDER:    big_endian = data[0];
                REG_STATUS_FIRST:  status_block[3*STATUS_W-1 -: STATUS_W] = data;
                REG_STATUS_MIDDLE: status_block[2*STATUS_W-1 -: STATUS_W] = data;
                REG_STATUS_LAST:   status_block[STATUS_W-1:0] = data;
                default: ;
            endcase
        endfunction

        function logic [31:0] subframe(logic [1:0] pre, logic [15:0] sample, logic cs);
            return {1'b0, cs, 2'b00, sample, 10'b0, pre};
        endfunction

        function int pending_count();
            return pending_words.size();
        endfunction

        function void note_frame(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                 logic [7:0] b3, logic muted);
            out_word_t   exp_word;
            logic [15:0] left_s;
            logic [15:0] right_s;
            logic        cs;
            logic [1:0]  pre;
            if (!spdif_mode) begin
                if (!big_endian)
                    exp_word.word = stereo ? {b3, b2, b1, b0} : {b1, b0, b1, b0};
                else
                    exp_word.word = stereo ? {b2, b3, b0, b1} : {b0, b1, b0, b1};
                exp_word.last = 1'b1;
                pending_words.push_back(exp_word);
                analog_frames++;
                return;
            end
            left_s  = big_endian ? {b0, b1} : {b1, b0};
            right_s = big_endian ? {b2, b3} : {b3, b2};
            if (!stereo)
                right_s = left_s;
            if (muted)
            begin
                left_s  = '0;
                right_s = '0;
                muted_frames++;
            end
            cs  = status_block[3*STATUS_W-1 - frame_pos];
            pre = (frame_pos == 0) ? PREAMBLE_B : PREAMBLE_M;
            exp_word.word = subframe(pre, left_s, cs);
            exp_word.last = 1'b0;
            pending_words.push_back(exp_word);
            exp_word.word = subframe(PREAMBLE_W, right_s, cs);
            exp_word.last = 1'b1;
            pending_words.push_back(exp_word);
            spdif_frames++;
            if (frame_pos == STATUS_FRAMES - 1)
            begin
                frame_pos = '0;
                block_wraps++;
            end
            else
                frame_pos++;
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("mismatch at word %0d: %s", words_checked, what);
        endtask

        task check_word(logic [31:0] got_word, logic got_last);
            out_word_t want;
            if (pending_words.size() == 0)
            begin
                report_mismatch($sformatf("word %h last %b with nothing expected",
                                          got_word, got_last));
                return;
            end
            want = pending_words.pop_front();
            words_checked++;
            if (got_word !== want.word)
                report_mismatch($sformatf("word %h, want %h", got_word, want.word));
            if (got_last !== want.last)
                report_mismatch($sformatf("last %b, want %b", got_last, want.last));
        endtask
    endclass

endpackage

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives PCM frames through the formatter in every output mode, channel
// setting and byte order, with changing channel status blocks, random
// sender bursts and receiver stalls, and checks every output word in order.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import spf_pkg::*;
    import spf_frame_board_pkg::*;

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HEAVY} stall_style_t;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [STATUS_W-1:0]    cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    logic [7:0]             byte0     = '0;
    logic [7:0]             byte1     = '0;
    logic [7:0]             byte2     = '0;
    logic [7:0]             byte3     = '0;
    logic                   mute      = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [31:0]            word;
    logic                   last;

    frame_board   board = new();
    stall_style_t stall_style = STALL_NONE;
    int           style_left  = 0;
    int           stall_tick  = 0;

    spdif_pcm_frame_formatter_core u_top (.*);

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // receiver stall pattern, switching to a randomly chosen style now and then
    always @(negedge clk)
    begin
        if (style_left == 0)
        begin
            stall_style = stall_style_t'($urandom_range(0, 3));
            style_left  = $urandom_range(20, 120);
        end
        style_left--;
        stall_tick++;
        case (stall_style)
            STALL_NONE:     out_stall = 1'b0;
            STALL_RANDOM:   out_stall = ($urandom_range(0, 99) < 35);
            STALL_PERIODIC: out_stall = (stall_tick % 3 == 0);
            default:        out_stall = ($urandom_range(0, 99) < 85);
        endcase
    end

    // accepted frames are noted before the same edge's word is checked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                board.note_frame(byte0, byte1, byte2, byte3, mute);
            if (out_valid && !out_stall)
                board.check_word(word, last);
        end
    end

    function automatic logic [STATUS_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [STATUS_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge clk); while (!cfg_ready);
        board.write_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // upper bits of the one-bit registers carry junk
    task automatic set_format(input logic spdif, input logic two_ch, input logic big);
        logic [STATUS_W-1:0] junk;
        junk = rand64();
        junk[0] = spdif;
        write_reg(REG_OUTPUT_MODE, junk);
        junk = rand64();
        junk[0] = two_ch;
        write_reg(REG_STEREO, junk);
        junk = rand64();
        junk[0] = big;
        write_reg(REG_BYTE_ORDER, junk);
    endtask

    task automatic load_status(input logic [STATUS_W-1:0] first_bits,
                               input logic [STATUS_W-1:0] middle_bits,
                               input logic [STATUS_W-1:0] last_bits);
        write_reg(REG_STATUS_FIRST, first_bits);
        write_reg(REG_STATUS_MIDDLE, middle_bits);
        write_reg(REG_STATUS_LAST, last_bits);
    endtask

    task automatic send_frame(input logic [7:0] b0, input logic [7:0] b1,
                              input logic [7:0] b2, input logic [7:0] b3,
                              input logic m);
        @(negedge clk);
        in_valid = 1'b1;
        byte0    = b0;
        byte1    = b1;
        byte2    = b2;
        byte3    = b3;
        mute     = m;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic idle_frames(input int n);
        if (n == 0)
            return;
        @(negedge clk);
        in_valid = 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic run_frames(input int n, input bit gaps);
        int burst;
        while (n > 0)
        begin
            burst = $urandom_range(1, 16);
            for (int k = 0; k < burst && n > 0; k++)
            begin
                send_frame(rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                           $urandom_range(0, 3) == 0);
                n--;
            end
            if (gaps)
                idle_frames($urandom_range(0, 6));
        end
    endtask

    // stop sending and wait for every expected word
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (board.pending_count() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        logic [2:0] combo;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(posedge clk);

        // out of reset: analog, stereo, little-endian; mute does nothing here
        send_frame(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        send_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_frame(8'h01, 8'h23, 8'h45, 8'h67, 1'b1);
        drain();
        set_format(1'b0, 1'b1, 1'b1);
        send_frame(8'h12, 8'h34, 8'h56, 8'h78, 1'b0);
        send_frame(8'h80, 8'h7F, 8'h01, 8'hFE, 1'b0);
        drain();
        set_format(1'b0, 1'b0, 1'b0);
        send_frame(8'hA5, 8'h5A, 8'hFF, 8'h00, 1'b0);
        send_frame(8'h00, 8'hFF, 8'h12, 8'h34, 1'b1);
        drain();
        set_format(1'b0, 1'b0, 1'b1);
        send_frame(8'hC3, 8'h3C, 8'h99, 8'h66, 1'b0);
        send_frame(8'hFF, 8'h00, 8'h00, 8'hFF, 1'b0);
        drain();
        // writes past the register map leave the format alone
        write_reg(REG_SPARE_A, '1);
        write_reg(REG_SPARE_B, rand64());
        send_frame(8'h11, 8'h22, 8'h33, 8'h44, 1'b0);
        drain();

        // S/PDIF: first frame carries preamble B at block position 0
        load_status(64'h8000_0000_0000_0001, '1, 64'hA5A5_0F0F_3C3C_5AA5);
        set_format(1'b1, 1'b1, 1'b0);
        send_frame(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        send_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_frame(8'h01, 8'h80, 8'h7F, 8'hFE, 1'b0);
        drain();
        set_format(1'b1, 1'b1, 1'b1);
        send_frame(8'h01, 8'h80, 8'h7F, 8'hFE, 1'b0);
        send_frame(8'hFF, 8'h00, 8'h00, 8'hFF, 1'b1);
        drain();
        set_format(1'b1, 1'b0, 1'b0);
        send_frame(8'h34, 8'h12, 8'hEE, 8'hDD, 1'b0);
        send_frame(8'h00, 8'hFF, 8'hFF, 8'h00, 1'b0);
        drain();
        set_format(1'b1, 1'b0, 1'b1);
        send_frame(8'h12, 8'h34, 8'h56, 8'h78, 1'b1);
        send_frame(8'hFF, 8'h01, 8'h00, 8'h00, 1'b0);

        // random phases: every format combination, then a couple more
        for (int p = 0; p < 10; p++)
        begin
            drain();
            combo = (p < 8) ? 3'(p) : 3'($urandom);
            if (p == 2)
                load_status('0, '0, '0);
            else if (p == 5)
                load_status('1, '1, '1);
            else
                load_status(rand64(), rand64(), rand64());
            if ($urandom_range(0, 2) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, rand64());
            set_format(combo[2], combo[1], combo[0]);
            run_frames(combo[2] ? 60 : 20, (p % 3) != 1);
        end

        drain();
        repeat (8) @(posedge clk);
        if (board.pending_count() != 0)
            board.report_mismatch($sformatf("%0d words never came", board.pending_count()));
        $display("covered %0d analog and %0d S/PDIF frames (%0d muted), %0d words checked",
                 board.analog_frames, board.spdif_frames, board.muted_frames,
                 board.words_checked);
        $display("status block wrapped %0d times, %0d mismatches",
                 board.block_wraps, board.errors);
        if (board.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #(5ms);
        $display("run timed out");
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
